/* hdl/sqd_pkg.sv */
package sqd_pkg;

  // queue geometry and data width
  localparam int QDEPTH     = 16;
  localparam int NUM_QUEUES = 4;
  localparam int DATA_WIDTH = 32;

  localparam int PTR_W  = $clog2(QDEPTH + 1);
  localparam int QIDX_W = $clog2(NUM_QUEUES);
  localparam int SLOTS  = NUM_QUEUES * QDEPTH;
  localparam int ADDR_W = $clog2(SLOTS);

  // opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] data_in;
  } sqd_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         queue_index;
    logic signed [31:0] data_out;
  } sqd_out_t;

  // decision for one transaction, from the scheduler to the datapath
  typedef struct packed {
    logic [1:0]        status;
    logic [QIDX_W-1:0] qidx;
    logic [ADDR_W-1:0] addr;
    logic              mem_we;
    logic              mem_re;
  } sqd_cmd_t;

endpackage

/* hdl/sqd_ram.sv */
module sqd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single write port, registered read that holds when not enabled
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/sqd_sched.sv */
module sqd_sched import sqd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     go,
  input  logic     opcode,
  output sqd_cmd_t cmd
);

  logic [PTR_W-1:0]  head_r   [NUM_QUEUES];
  logic [PTR_W-1:0]  tail_r   [NUM_QUEUES];
  logic [PTR_W-1:0]  head_nxt [NUM_QUEUES];
  logic [PTR_W-1:0]  tail_nxt [NUM_QUEUES];
  logic [PTR_W-1:0]  fill     [NUM_QUEUES];
  logic [QIDX_W-1:0] short_q;
  logic [QIDX_W-1:0] long_q;
  logic [QIDX_W-1:0] sel;
  logic [ADDR_W-1:0] base;
  logic              full;
  logic              empty;

  // per-queue occupancy
  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      fill[q] = tail_r[q] - head_r[q];
    end
  end

  // shortest and longest queue, lowest index wins ties
  always_comb begin
    short_q = '0;
    long_q  = '0;
    for (int q = 1; q < NUM_QUEUES; q++) begin
      if (fill[q] < fill[short_q]) begin
        short_q = QIDX_W'(q);
      end
      if (fill[q] > fill[long_q]) begin
        long_q = QIDX_W'(q);
      end
    end
  end

  // decision for the incoming transaction
  always_comb begin
    sel   = (opcode == OP_DELETE) ? long_q : short_q;
    base  = ADDR_W'(sel) * ADDR_W'(QDEPTH);
    full  = (tail_r[sel] == PTR_W'(QDEPTH));
    empty = (fill[sel] == '0);
    cmd.qidx   = sel;
    if (opcode == OP_DELETE) begin
      cmd.status = empty ? ST_UNDERFLOW : ST_DONE;
      cmd.addr   = base + ADDR_W'(head_r[sel]);
      cmd.mem_we = 1'b0;
      cmd.mem_re = !empty;
    end else begin
      cmd.status = full ? ST_OVERFLOW : ST_DONE;
      cmd.addr   = base + ADDR_W'(tail_r[sel]);
      cmd.mem_we = !full;
      cmd.mem_re = 1'b0;
    end
  end

  // pointer advance
  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      head_nxt[q] = head_r[q];
      tail_nxt[q] = tail_r[q];
    end
    if (go && cmd.mem_we) begin
      tail_nxt[sel] = tail_r[sel] + PTR_W'(1);
    end
    if (go && cmd.mem_re) begin
      head_nxt[sel] = head_r[sel] + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head_r[q] <= '0;
        tail_r[q] <= '0;
      end
    end else begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head_r[q] <= head_nxt[q];
        tail_r[q] <= tail_nxt[q];
      end
    end
  end

endmodule

/* hdl/shortest_queue_dispatch_fifos_top.sv */
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+--------------------------------------
// input    | in_valid  | in_stall  | in_data  (opcode, data_in)
// result   | out_valid | out_stall | out_data (status, queue_index, data_out)
//
// one transaction per cycle while in_stall is low; a taken input is registered
// in the read stage with the registered read of the slot memory, then in the
// result register, which drives out_valid.
// synchronous active-low reset clears the pointers and pipeline valids; the
// slot memory needs no clearing pass since only written slots are ever read.
// out_stall backs up through the result register and the read stage to in_stall.
module shortest_queue_dispatch_fifos_top import sqd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sqd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sqd_out_t out_data
);

  sqd_cmd_t          cmd;
  logic              go;
  logic              out_free;
  logic              s1_free;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;

  logic              s1_valid_r;
  logic [1:0]        s1_status_r;
  logic [QIDX_W-1:0] s1_qidx_r;
  logic              s1_rd_r;
  logic              out_valid_r;
  sqd_out_t          out_data_r;

  // flow control
  assign out_free = !out_valid_r || !out_stall;
  assign s1_free  = !s1_valid_r || out_free;
  assign in_stall = !s1_free;
  assign go       = in_valid && s1_free;

  sqd_sched u_sched (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .opcode (in_data.opcode),
    .cmd    (cmd)
  );

  assign wdata = DATA_WIDTH'($unsigned(in_data.data_in));

  sqd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (go && cmd.mem_we),
    .waddr (cmd.addr),
    .wdata (wdata),
    .re    (go && cmd.mem_re),
    .raddr (cmd.addr),
    .rdata (rdata)
  );

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= go;
    end
    if (go) begin
      s1_status_r <= cmd.status;
      s1_qidx_r   <= cmd.qidx;
      s1_rd_r     <= cmd.mem_re;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
    if (out_free && s1_valid_r) begin
      out_data_r.status      <= s1_status_r;
      out_data_r.queue_index <= 2'(s1_qidx_r);
      out_data_r.data_out    <= s1_rd_r ? 32'(rdata) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_stall_needs_full_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in the pipeline");

  a_read_data_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(rdata)))
    else $error("read data lost while read stage stalled");

  a_underflow_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_UNDERFLOW) |-> (out_data_r.data_out == '0))
    else $error("underflow result carries data");

  a_overflow_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_OVERFLOW) |-> (out_data_r.data_out == '0))
    else $error("overflow result carries data");
`endif

endmodule
